// ===== rtl/core/sncl_pkg.sv =====
// ----------------------------------------------------------------------------
// sncl_pkg
// Types, constants and helpers shared by the segment norm band clamp block.
// ----------------------------------------------------------------------------
package sncl_pkg;

    localparam int SEG_LEN      = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 31;
    localparam logic [16:0] GAMMA_ONE = 17'd65536;

    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_BOUND  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_BOUND  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_ENABLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_ENABLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RELAX_GAMMA  = 3'd4;

    typedef struct packed {
        logic signed [31:0] gx_0;
        logic signed [31:0] gx_1;
        logic signed [31:0] gx_2;
        logic signed [31:0] offset_0;
        logic signed [31:0] offset_1;
        logic signed [31:0] offset_2;
        logic               first_segment;
    } t_seg_word;

    typedef struct packed {
        logic signed [31:0] out_0;
        logic signed [31:0] out_1;
        logic signed [31:0] out_2;
        logic        [31:0] clamped_norm;
        logic               zero_norm_flag;
    } t_res_word;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_SQ   = 8'b0000_0010,
        S_SQRT = 8'b0000_0100,
        S_RLX  = 8'b0000_1000,
        S_CHK  = 8'b0001_0000,
        S_MUL  = 8'b0010_0000,
        S_DIV  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    // saturate a 35 bit signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [34:0] x);
        logic signed [31:0] y;
        if (x > 35'sd2147483647) begin
            y = 32'sh7fffffff;
        end else if (x < -35'sd2147483648) begin
            y = 32'sh80000000;
        end else begin
            y = x[31:0];
        end
        return y;
    endfunction

    function automatic logic [32:0] mag34(input logic signed [33:0] x);
        logic [33:0] a;
        a = x[33] ? 34'(-x) : 34'(x);
        return a[32:0];
    endfunction

endpackage

// ===== rtl/core/sncl_seg_if.sv =====
// ----------------------------------------------------------------------------
// sncl_seg_if
// Input channel: one segment word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sncl_seg_if;
    logic                 valid;
    logic                 ready;
    sncl_pkg::t_seg_word  data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/core/sncl_res_if.sv =====
// ----------------------------------------------------------------------------
// sncl_res_if
// Output channel: one result word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sncl_res_if;
    logic                 valid;
    logic                 ready;
    sncl_pkg::t_res_word  data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/core/segment_norm_band_clamp_unit.sv =====
// ----------------------------------------------------------------------------
// segment_norm_band_clamp_unit
// Band clamp on the norm of one 3-vector segment, bit-serial sqrt and divide.
// ----------------------------------------------------------------------------
// Usage: a segment word enters on i_seg, a result word leaves on o_res, both
// valid/ready. Registers are to be written through i_cfg_we/i_cfg_addr/
// i_cfg_data by the user while the block is idle; the block does not enforce
// this. Indexes above 4 are ignored. One word is processed at a time;
// i_seg.ready is high only while idle. Steps after accept: squaring,
// bit-serial square root (two bits of the sum per cycle), then for each
// enabled bound relaxation and compare, and when that bound clamps
// shift-subtract division of each of the three components (one quotient bit
// per cycle), and last the load of the output register.
// The output register lets a new word be accepted while a result waits;
// a finished word stays in the last state until the output register is free.
// Reset clears the handshake, the registers to their reset values and the
// previous norm to zero.
// ----------------------------------------------------------------------------
module segment_norm_band_clamp_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    sncl_seg_if.sink                              i_seg,
    sncl_res_if.source                            o_res,
    input  logic                                  i_cfg_we,
    input  logic [sncl_pkg::CFG_IDX_W-1:0]        i_cfg_addr,
    input  logic [sncl_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    sncl_pkg::t_state   r_state;
    logic [5:0]         r_cnt;
    logic [1:0]         r_k;
    logic               r_phase;
    logic signed [33:0] r_v   [sncl_pkg::SEG_LEN];
    logic signed [31:0] r_off [sncl_pkg::SEG_LEN];
    logic               r_first;
    logic [63:0]        r_prod;
    logic [63:0]        r_acc;
    logic [32:0]        r_rem;
    logic [31:0]        r_root;
    logic [31:0]        r_norm;
    logic [31:0]        r_b;
    logic [48:0]        r_p;
    logic [48:0]        r_sum;
    logic [63:0]        r_num;
    logic [31:0]        r_drem;
    logic [32:0]        r_q;
    logic               r_flag;
    logic [31:0]        r_prev;
    logic [30:0]        r_upper;
    logic [30:0]        r_lower;
    logic               r_upper_en;
    logic               r_lower_en;
    logic [16:0]        r_gamma;
    sncl_pkg::t_res_word r_out;
    logic               r_out_valid;

    logic               in_acc;
    logic signed [33:0] sq_v;
    logic [32:0]        sq_abs;
    logic [31:0]        sq_mag;
    logic [34:0]        rem_sh;
    logic [34:0]        trial;
    logic [16:0]        n_g;
    logic [16:0]        n_ginv;
    logic [30:0]        n_bnd;
    logic               n_en;
    logic [32:0]        n_mag;
    logic [63:0]        n_num;
    logic [32:0]        div_sh;
    logic               div_ge;
    logic [32:0]        n_q;
    logic [49:0]        rlx_sum;
    logic signed [32:0] n_sum [sncl_pkg::SEG_LEN];

    assign in_acc      = i_seg.valid && i_seg.ready;
    assign i_seg.ready = (r_state == sncl_pkg::S_IDLE);
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    assign n_sum[0] = 33'(i_seg.data.gx_0) + 33'(i_seg.data.offset_0);
    assign n_sum[1] = 33'(i_seg.data.gx_1) + 33'(i_seg.data.offset_1);
    assign n_sum[2] = 33'(i_seg.data.gx_2) + 33'(i_seg.data.offset_2);

    always_comb begin
        unique case (r_cnt[1:0])
            2'd0:    sq_v = r_v[0];
            2'd1:    sq_v = r_v[1];
            2'd2:    sq_v = r_v[2];
            default: sq_v = '0;
        endcase
    end

    assign sq_abs = sncl_pkg::mag34(sq_v);
    assign sq_mag = sq_abs[31:0];

    assign rem_sh = {r_rem, r_acc[63:62]};
    assign trial  = {1'b0, r_root, 2'b01};

    assign n_g    = (r_gamma > sncl_pkg::GAMMA_ONE) ? sncl_pkg::GAMMA_ONE : r_gamma;
    assign n_ginv = sncl_pkg::GAMMA_ONE - n_g;
    assign n_bnd  = r_phase ? r_lower : r_upper;
    assign n_en   = r_phase ? r_lower_en : r_upper_en;
    assign rlx_sum = 50'(r_sum) + 50'(r_p);

    assign n_mag  = sncl_pkg::mag34(r_v[r_k]);
    assign n_num  = 64'(n_mag * r_b) + 64'(r_norm >> 1);

    assign div_sh = {r_drem, r_num[63]};
    assign div_ge = (div_sh >= {1'b0, r_norm});
    assign n_q    = {r_q[31:0], div_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sncl_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_prev      <= '0;
            r_upper     <= 31'h7fffffff;
            r_lower     <= '0;
            r_upper_en  <= 1'b0;
            r_lower_en  <= 1'b0;
            r_gamma     <= sncl_pkg::GAMMA_ONE;
            r_cnt       <= '0;
            r_k         <= '0;
            r_phase     <= 1'b0;
            r_flag      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    sncl_pkg::CFG_UPPER_BOUND:  r_upper    <= i_cfg_data;
                    sncl_pkg::CFG_LOWER_BOUND:  r_lower    <= i_cfg_data;
                    sncl_pkg::CFG_UPPER_ENABLE: r_upper_en <= i_cfg_data[0];
                    sncl_pkg::CFG_LOWER_ENABLE: r_lower_en <= i_cfg_data[0];
                    sncl_pkg::CFG_RELAX_GAMMA:  r_gamma    <= i_cfg_data[16:0];
                    default: ;
                endcase
            end
            if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                sncl_pkg::S_IDLE: begin
                    if (in_acc) begin
                        for (int i = 0; i < sncl_pkg::SEG_LEN; i++) begin
                            r_v[i] <= 34'(sncl_pkg::sat32(35'(n_sum[i])));
                        end
                        r_off[0] <= i_seg.data.offset_0;
                        r_off[1] <= i_seg.data.offset_1;
                        r_off[2] <= i_seg.data.offset_2;
                        r_first  <= i_seg.data.first_segment;
                        r_acc    <= '0;
                        r_cnt    <= '0;
                        r_phase  <= 1'b0;
                        r_flag   <= 1'b0;
                        r_state  <= sncl_pkg::S_SQ;
                    end
                end
                sncl_pkg::S_SQ: begin
                    r_prod <= 64'(sq_mag * sq_mag);
                    if (r_cnt != 6'd0) begin
                        r_acc <= r_acc + r_prod;
                    end
                    if (r_cnt == 6'd3) begin
                        r_cnt   <= '0;
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_state <= sncl_pkg::S_SQRT;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                sncl_pkg::S_SQRT: begin
                    r_acc <= r_acc << 2;
                    if (rem_sh >= trial) begin
                        r_rem  <= 33'(rem_sh - trial);
                        r_root <= {r_root[30:0], 1'b1};
                    end else begin
                        r_rem  <= rem_sh[32:0];
                        r_root <= {r_root[30:0], 1'b0};
                    end
                    if (r_cnt == 6'd31) begin
                        r_cnt   <= '0;
                        r_state <= sncl_pkg::S_RLX;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                sncl_pkg::S_RLX: begin
                    if (r_cnt == 6'd0 && r_phase == 1'b0) begin
                        r_norm <= r_root;
                    end
                    priority if (!n_en) begin
                        r_cnt <= '0;
                        if (r_phase) begin
                            r_state <= sncl_pkg::S_DONE;
                        end else begin
                            r_phase <= 1'b1;
                        end
                    end else if (r_first) begin
                        r_b     <= {1'b0, n_bnd};
                        r_state <= sncl_pkg::S_CHK;
                    end else if (r_cnt == 6'd0) begin
                        r_p   <= 49'(n_g * n_bnd);
                        r_cnt <= 6'd1;
                    end else if (r_cnt == 6'd1) begin
                        r_sum <= r_p;
                        r_p   <= 49'(n_ginv * r_prev);
                        r_cnt <= 6'd2;
                    end else begin
                        r_b     <= rlx_sum[47:16];
                        r_cnt   <= '0;
                        r_state <= sncl_pkg::S_CHK;
                    end
                end
                sncl_pkg::S_CHK: begin
                    r_k   <= '0;
                    r_cnt <= '0;
                    if (!r_phase) begin
                        if (r_norm > r_b) begin
                            r_state <= sncl_pkg::S_MUL;
                        end else begin
                            r_phase <= 1'b1;
                            r_state <= sncl_pkg::S_RLX;
                        end
                    end else begin
                        priority if (r_norm >= r_b) begin
                            r_state <= sncl_pkg::S_DONE;
                        end else if (r_norm == 32'd0) begin
                            r_flag  <= 1'b1;
                            r_state <= sncl_pkg::S_DONE;
                        end else begin
                            r_state <= sncl_pkg::S_MUL;
                        end
                    end
                end
                sncl_pkg::S_MUL: begin
                    r_num   <= n_num << 31;
                    r_drem  <= {1'b0, n_num[63:33]};
                    r_q     <= '0;
                    r_cnt   <= '0;
                    r_state <= sncl_pkg::S_DIV;
                end
                sncl_pkg::S_DIV: begin
                    r_num <= r_num << 1;
                    r_q   <= n_q;
                    r_drem <= div_ge ? 32'(div_sh - {1'b0, r_norm}) : div_sh[31:0];
                    if (r_cnt == 6'd32) begin
                        r_cnt  <= '0;
                        r_v[r_k] <= r_v[r_k][33] ? -$signed({1'b0, n_q})
                                                 : $signed({1'b0, n_q});
                        if (r_k == 2'd2) begin
                            r_norm <= r_b;
                            if (r_phase) begin
                                r_state <= sncl_pkg::S_DONE;
                            end else begin
                                r_phase <= 1'b1;
                                r_state <= sncl_pkg::S_RLX;
                            end
                        end else begin
                            r_k     <= r_k + 2'd1;
                            r_state <= sncl_pkg::S_MUL;
                        end
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                sncl_pkg::S_DONE: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_out.out_0 <= sncl_pkg::sat32(35'(r_v[0]) - 35'(r_off[0]));
                        r_out.out_1 <= sncl_pkg::sat32(35'(r_v[1]) - 35'(r_off[1]));
                        r_out.out_2 <= sncl_pkg::sat32(35'(r_v[2]) - 35'(r_off[2]));
                        r_out.clamped_norm   <= r_norm;
                        r_out.zero_norm_flag <= r_flag;
                        r_prev      <= r_norm;
                        r_out_valid <= 1'b1;
                        r_state     <= sncl_pkg::S_IDLE;
                    end
                end
                default: r_state <= sncl_pkg::S_IDLE;
            endcase
        end
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == sncl_pkg::S_SQ))
        else $error("accepted word did not start squaring");

    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.zero_norm_flag) |-> (r_out.clamped_norm == 32'd0))
        else $error("zero norm flag with nonzero norm");

    a_sqrt_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sncl_pkg::S_SQRT) |-> (r_cnt < 6'd32))
        else $error("square root ran past its steps");

    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == sncl_pkg::S_DONE))
        else $error("result raised outside done state");

endmodule

// ===== verif/sncl_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sncl_checker
// Watches the segment and result channels and the register port of the
// segment norm band clamp unit, predicts each result word from the accepted
// segment word and compares them field by field, in order.
// ----------------------------------------------------------------------------
module sncl_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    sncl_seg_if                             seg,
    sncl_res_if                             res,
    input  logic                            i_cfg_we,
    input  logic [sncl_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [sncl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);

    logic [30:0] upper_lim;
    logic [30:0] lower_lim;
    logic        upper_on;
    logic        lower_on;
    logic [16:0] gamma;
    logic [31:0] last_norm;
    sncl_pkg::t_res_word clamp_q[$];
    int          fail_count;

    function automatic longint clip32(input longint x);
        longint y;
        y = x;
        if (x > 64'sd2147483647) y = 64'sd2147483647;
        if (x < -64'sd2147483648) y = -64'sd2147483648;
        return y;
    endfunction

    function automatic logic [31:0] root_of(input longint unsigned n);
        longint unsigned root;
        longint unsigned probe;
        longint unsigned rest;
        root = 0;
        rest = n;
        probe = 64'h4000_0000_0000_0000;
        while (probe > rest) probe = probe >> 2;
        while (probe != 0) begin
            if (rest >= root + probe) begin
                rest = rest - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root[31:0];
    endfunction

    function automatic logic [31:0] relax(input logic [31:0] lim, input logic first);
        longint unsigned g;
        longint unsigned t;
        g = (gamma > sncl_pkg::GAMMA_ONE) ? 64'd65536 : longint'(gamma);
        t = g * longint'(lim) + (64'd65536 - g) * longint'(last_norm);
        return first ? lim : t[47:16];
    endfunction

    function automatic longint scale_comp(input longint x, input longint unsigned target,
                                          input longint unsigned n);
        longint unsigned m;
        longint unsigned q;
        m = (x < 0) ? longint'(-x) : longint'(x);
        q = (m * target + (n >> 1)) / n;
        return (x < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic sncl_pkg::t_res_word clamp_segment(input sncl_pkg::t_seg_word w);
        longint          vec [sncl_pkg::SEG_LEN];
        longint          off [sncl_pkg::SEG_LEN];
        longint unsigned sumsq;
        longint unsigned mag;
        logic [31:0]     nrm;
        logic [31:0]     lim;
        logic            flag;
        longint          o [sncl_pkg::SEG_LEN];
        sncl_pkg::t_res_word r;
        off[0] = longint'(w.offset_0);
        off[1] = longint'(w.offset_1);
        off[2] = longint'(w.offset_2);
        vec[0] = clip32(longint'(w.gx_0) + off[0]);
        vec[1] = clip32(longint'(w.gx_1) + off[1]);
        vec[2] = clip32(longint'(w.gx_2) + off[2]);
        sumsq = 0;
        flag = 1'b0;
        for (int k = 0; k < sncl_pkg::SEG_LEN; k++) begin
            mag = (vec[k] < 0) ? longint'(-vec[k]) : longint'(vec[k]);
            sumsq += mag * mag;
        end
        nrm = root_of(sumsq);
        if (upper_on) begin
            lim = relax({1'b0, upper_lim}, w.first_segment);
            if (nrm > lim) begin
                for (int k = 0; k < sncl_pkg::SEG_LEN; k++)
                    vec[k] = scale_comp(vec[k], lim, nrm);
                nrm = lim;
            end
        end
        if (lower_on) begin
            lim = relax({1'b0, lower_lim}, w.first_segment);
            if (nrm < lim) begin
                if (nrm == 0) begin
                    flag = 1'b1;
                end else begin
                    for (int k = 0; k < sncl_pkg::SEG_LEN; k++)
                        vec[k] = scale_comp(vec[k], lim, nrm);
                    nrm = lim;
                end
            end
        end
        last_norm = nrm;
        for (int k = 0; k < sncl_pkg::SEG_LEN; k++) o[k] = clip32(vec[k] - off[k]);
        r.out_0 = o[0][31:0];
        r.out_1 = o[1][31:0];
        r.out_2 = o[2][31:0];
        r.clamped_norm = nrm;
        r.zero_norm_flag = flag;
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t mismatch %s: got %h, want %h", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        sncl_pkg::t_res_word want;
        if (!i_rst_n) begin
            upper_lim <= 31'h7fffffff;
            lower_lim <= '0;
            upper_on  <= 1'b0;
            lower_on  <= 1'b0;
            gamma     <= sncl_pkg::GAMMA_ONE;
            last_norm = '0;
            clamp_q.delete();
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    sncl_pkg::CFG_UPPER_BOUND:  upper_lim <= i_cfg_data;
                    sncl_pkg::CFG_LOWER_BOUND:  lower_lim <= i_cfg_data;
                    sncl_pkg::CFG_UPPER_ENABLE: upper_on  <= i_cfg_data[0];
                    sncl_pkg::CFG_LOWER_ENABLE: lower_on  <= i_cfg_data[0];
                    sncl_pkg::CFG_RELAX_GAMMA:  gamma     <= i_cfg_data[16:0];
                    default: ;
                endcase
            end
            if (res.valid && res.ready) begin
                if (clamp_q.size() == 0) begin
                    report("unexpected word", res.data.clamped_norm, '0);
                end else begin
                    want = clamp_q.pop_front();
                    if (res.data.out_0 !== want.out_0) report("out_0", res.data.out_0, want.out_0);
                    if (res.data.out_1 !== want.out_1) report("out_1", res.data.out_1, want.out_1);
                    if (res.data.out_2 !== want.out_2) report("out_2", res.data.out_2, want.out_2);
                    if (res.data.clamped_norm !== want.clamped_norm)
                        report("clamped_norm", res.data.clamped_norm, want.clamped_norm);
                    if (res.data.zero_norm_flag !== want.zero_norm_flag)
                        report("zero_norm_flag", 32'(res.data.zero_norm_flag),
                               32'(want.zero_norm_flag));
                end
            end
            if (seg.valid && seg.ready) clamp_q.push_back(clamp_segment(seg.data));
        end
        o_pending = clamp_q.size();
    end

    initial begin
        fail_count = 0;
        o_pending = 0;
        last_norm = '0;
    end

    assign o_fail_count = fail_count;

endmodule

// ===== verif/segment_norm_band_clamp_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_norm_band_clamp_unit_tb
// Drives segment words with random gaps and result back-pressure through a
// series of bound, enable and gamma settings, from directed corner words to
// long random runs of segments; the checker scores every result word.
// ----------------------------------------------------------------------------
module segment_norm_band_clamp_unit_tb;

    localparam int DRAIN_CYCLES = 300;
    localparam int STALL_LIMIT  = 5000;
    localparam int PHASE_WORDS  = 165;
    localparam logic [sncl_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [sncl_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [sncl_pkg::CFG_IDX_W-1:0]  i_cfg_addr = '0;
    logic [sncl_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                            calm = 1'b0;
    int                              fail_count;
    int                              pending;
    int                              idle_cycles = 0;
    int                              hold_left = 0;

    sncl_seg_if seg_ch ();
    sncl_res_if res_ch ();

    segment_norm_band_clamp_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_seg      (seg_ch),
        .o_res      (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data)
    );

    sncl_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .seg          (seg_ch),
        .res          (res_ch),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        seg_ch.valid = 1'b0;
        seg_ch.data  = '0;
        res_ch.ready = 1'b0;
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            res_ch.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            hold_left <= $urandom_range(0, 11);
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((seg_ch.valid && seg_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    function automatic logic [31:0] rand_comp();
        logic [31:0] v;
        int          sh;
        case ($urandom_range(0, 6))
            0, 1: v = $urandom;
            2: v = 32'h7fffffff;
            3: v = 32'h80000000;
            4: v = '0;
            default: begin
                sh = $urandom_range(4, 31);
                v = $urandom & ((32'd1 << sh) - 1);
                if ($urandom_range(0, 1)) v = -v;
            end
        endcase
        return v;
    endfunction

    function automatic sncl_pkg::t_seg_word make_word(input logic [31:0] g0, g1, g2,
                                                      o0, o1, o2, input logic first);
        sncl_pkg::t_seg_word w;
        w.gx_0 = g0;
        w.gx_1 = g1;
        w.gx_2 = g2;
        w.offset_0 = o0;
        w.offset_1 = o1;
        w.offset_2 = o2;
        w.first_segment = first;
        return w;
    endfunction

    task automatic send_word(input sncl_pkg::t_seg_word w);
        if (!calm && $urandom_range(0, 7) == 0) begin
            seg_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        seg_ch.valid <= 1'b1;
        seg_ch.data  <= w;
        forever begin
            @(negedge i_clk);
            if (seg_ch.ready) break;
        end
        @(posedge i_clk);
    endtask

    task automatic settle();
        seg_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [sncl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sncl_pkg::CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic set_bounds(input logic [30:0] ub, lb, input logic ue, le,
                              input logic [16:0] g);
        settle();
        cfg_write(sncl_pkg::CFG_UPPER_BOUND, ub);
        cfg_write(sncl_pkg::CFG_LOWER_BOUND, lb);
        cfg_write(sncl_pkg::CFG_UPPER_ENABLE, {30'd0, ue});
        cfg_write(sncl_pkg::CFG_LOWER_ENABLE, {30'd0, le});
        cfg_write(sncl_pkg::CFG_RELAX_GAMMA, {14'd0, g});
        cfg_write(CFG_SPARE_LO, 31'($urandom));
        cfg_write(CFG_SPARE_HI, 31'($urandom));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_words(input int count);
        logic [31:0] c [6];
        for (int n = 0; n < count; n++) begin
            for (int k = 0; k < 6; k++) c[k] = rand_comp();
            send_word(make_word(c[0], c[1], c[2], c[3], c[4], c[5],
                                $urandom_range(0, 4) == 0));
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings, first segment marked at random
        random_words(40);

        set_bounds(31'd4 << 20, 31'd1 << 20, 1'b1, 1'b1, 17'd49152);
        send_word(make_word(0, 0, 0, 0, 0, 0, 1'b1));
        send_word(make_word(0, 0, 0, 0, 0, 0, 1'b0));
        send_word(make_word(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                            32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b1));
        send_word(make_word(32'h80000000, 32'h80000000, 32'h80000000,
                            32'h80000000, 32'h80000000, 32'h80000000, 1'b0));
        send_word(make_word(32'h7fffffff, 32'h80000000, 32'h7fffffff,
                            32'h80000000, 32'h7fffffff, 32'h7fffffff, 1'b0));
        send_word(make_word(32'd1, 0, 0, 0, 0, 0, 1'b1));
        send_word(make_word(0, -32'sd1, 0, 0, 0, 0, 1'b0));
        send_word(make_word(0, 0, 32'd2 << 20, 0, 0, 0, 1'b1));
        send_word(make_word(32'd4 << 20, 0, 0, 0, 0, 0, 1'b1));
        send_word(make_word(32'd3 << 20, 32'd4 << 20, 0, -32'sd5, 32'd7, 0, 1'b0));
        send_word(make_word(32'd5, -32'sd5, 32'd5, -32'sd5, 32'd5, -32'sd5, 1'b0));
        send_word(make_word(-32'sd3 << 18, 32'd1 << 18, 32'd2 << 18,
                            32'd100, -32'sd100, 32'd1, 1'b0));

        // lower bound above upper bound
        set_bounds(31'd1 << 20, 31'd3 << 20, 1'b1, 1'b1, 17'd32768);
        send_word(make_word(32'd10 << 20, 0, 0, 0, 0, 0, 1'b1));
        send_word(make_word(32'd1 << 10, 0, 0, 0, 0, 0, 1'b0));
        send_word(make_word(0, 0, 0, 32'd9, 32'd9, 32'd9, 1'b0));
        random_words(PHASE_WORDS);

        set_bounds(31'h7fffffff, 31'd0, 1'b1, 1'b1, 17'd0);
        random_words(PHASE_WORDS);

        set_bounds(31'd0, 31'd0, 1'b1, 1'b0, sncl_pkg::GAMMA_ONE);
        random_words(PHASE_WORDS / 2);

        set_bounds(31'($urandom_range(1 << 20, 1 << 30)), 31'($urandom_range(1, 1 << 20)),
                   1'b1, 1'b1, 17'h1ffff);
        random_words(PHASE_WORDS);

        set_bounds(31'd0, 31'h7fffffff, 1'b0, 1'b1, 17'($urandom_range(0, 65536)));
        random_words(PHASE_WORDS);

        set_bounds(31'($urandom), 31'($urandom), 1'b1, 1'b1,
                   17'($urandom_range(0, 131071)));
        random_words(PHASE_WORDS);

        set_bounds(31'd30 << 20, 31'd2 << 20, 1'b1, 1'b1, 17'($urandom_range(0, 65536)));
        random_words(PHASE_WORDS);

        calm <= 1'b1;
        set_bounds(31'd20 << 20, 31'd5 << 20, 1'b1, 1'b1, 17'd60000);
        random_words(PHASE_WORDS);

        settle();
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/sncl_pkg.sv
rtl/core/sncl_seg_if.sv
rtl/core/sncl_res_if.sv
rtl/core/segment_norm_band_clamp_unit.sv
verif/sncl_checker.sv
verif/segment_norm_band_clamp_unit_tb.sv
